>>> rtl/core/hpt_pkg.sv
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

	// Default number of fractional bits of coordinates and coefficients.
	localparam int FRAC_BITS_DEF = 16;
	// Width of one coordinate or coefficient.
	localparam int CW = 32;
	// Width of an exact row sum: four 64-bit terms.
	localparam int SUM_W = 66;
	// Quotient bits produced by the divider.
	localparam int QW = 32;
	// Number of configuration registers and their data width.
	localparam int NUM_CFG = 8;
	localparam int CFG_DW = 64;
	// Byte address width for eight 64-bit registers.
	localparam int CFG_AW = 6;
	// Number of matrix rows (lanes).
	localparam int NUM_ROWS = 4;

	// Status of one coordinate lane.
	typedef struct packed {
		logic w_zero;
		logic clip;
	} coord_flags_t;

endpackage

>>> rtl/core/hpt_lane.sv
// One matrix row: three products and the translation term, summed exactly.
module hpt_lane import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [CW-1:0]    x,
	input  logic signed [CW-1:0]    y,
	input  logic signed [CW-1:0]    z,
	input  logic [3:0][CW-1:0]      coef,
	output logic signed [SUM_W-1:0] sum_s2
);

	logic signed [2*CW-1:0]  p0_s1, p1_s1, p2_s1;
	logic signed [SUM_W-1:0] p3_s1;

	// Stage 1: the three products and the translation scaled to the product format.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= x * $signed(coef[0]);
			p1_s1 <= y * $signed(coef[1]);
			p2_s1 <= z * $signed(coef[2]);
			p3_s1 <= {{(SUM_W-CW-FRAC_BITS){coef[3][CW-1]}}, coef[3], {FRAC_BITS{1'b0}}};
		end
	end

	// Stage 2: exact sum of the four terms.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + p3_s1;
		end
	end

endmodule

>>> rtl/core/hpt_coord.sv
// Perspective divide and saturation of one coordinate, pipelined one quotient bit per stage.
module hpt_coord import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [SUM_W-1:0] t,
	input  logic signed [SUM_W-1:0] w,
	output logic [CW-1:0]           coord_s,
	output coord_flags_t            flags_s
);

	localparam int RW = SUM_W + QW;
	localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic          rneg;
		logic          ovf;
		logic          use_fast;
		logic          w_zero;
		logic          fclip;
		logic [CW-1:0] fast;
	} side_t;

	logic                    t_neg, w_neg, w_zero, w_one, in_range;
	logic [SUM_W-1:0]        t_mag, w_mag;
	logic signed [SUM_W-1:0] t_shr;
	logic [CW-1:0]           fast_val;
	logic                    fast_clip;

	logic [SUM_W-1:0] mag_sa, den_sa;
	side_t            side_sa;
	logic [RW-1:0]    num_sb;
	side_t            side_sb;

	logic [RW-1:0]    rem_sd [QW+1];
	logic [SUM_W-1:0] den_sd [QW+1];
	logic [QW-1:0]    quo_sd [QW+1];
	side_t            side_sd [QW+1];

	// Signs, magnitudes and the cases that bypass the divider.
	always_comb begin
		t_neg    = t[SUM_W-1];
		w_neg    = w[SUM_W-1];
		t_mag    = t_neg ? SUM_W'(-t) : SUM_W'(t);
		w_mag    = w_neg ? SUM_W'(-w) : SUM_W'(w);
		w_zero   = (w == '0);
		w_one    = (w == (SUM_W'(1) << (2*FRAC_BITS)));
		t_shr    = t >>> FRAC_BITS;
		in_range = (&t_shr[SUM_W-1:CW-1]) | ~(|t_shr[SUM_W-1:CW-1]);
		fast_clip = 1'b0;
		if (w_zero) begin
			if (t == '0) fast_val = '0;
			else fast_val = t_neg ? NEG_MIN : POS_MAX;
		end else if (in_range) begin
			fast_val = t_shr[CW-1:0];
		end else begin
			fast_val  = t_neg ? NEG_MIN : POS_MAX;
			fast_clip = 1'b1;
		end
	end

	// Stage A: register magnitudes and the bypass result.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_sa           <= t_mag;
			den_sa           <= w_mag;
			side_sa.rneg     <= t_neg ^ w_neg;
			side_sa.ovf      <= 1'b0;
			side_sa.use_fast <= w_zero | w_one;
			side_sa.w_zero   <= w_zero;
			side_sa.fclip    <= fast_clip;
			side_sa.fast     <= fast_val;
		end
	end

	// Stage B: scale the numerator and flag quotients that do not fit in QW bits.
	always_comb begin
		num_sb      = RW'(mag_sa) << FRAC_BITS;
		side_sb     = side_sa;
		side_sb.ovf = (num_sb >= (RW'(den_sa) << QW));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]  <= num_sb;
			den_sd[0]  <= den_sa;
			quo_sd[0]  <= '0;
			side_sd[0] <= side_sb;
		end
	end

	// Restoring division, most significant quotient bit first.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [RW-1:0] dsh;
		logic          ge;
		always_comb begin
			dsh = RW'(den_sd[k]) << (QW-1-k);
			ge  = (rem_sd[k] >= dsh);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k+1]  <= ge ? (rem_sd[k] - dsh) : rem_sd[k];
				den_sd[k+1]  <= den_sd[k];
				quo_sd[k+1]  <= quo_sd[k] | (ge ? (QW'(1) << (QW-1-k)) : '0);
				side_sd[k+1] <= side_sd[k];
			end
		end
	end

	// Final stage: apply the sign and saturate, or take the bypass result.
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s.w_zero <= side_sd[QW].w_zero;
			if (side_sd[QW].use_fast) begin
				coord_s      <= side_sd[QW].fast;
				flags_s.clip <= side_sd[QW].fclip;
			end else if (side_sd[QW].rneg) begin
				if (!side_sd[QW].ovf && quo_sd[QW] <= NEG_MIN) begin
					coord_s      <= ~quo_sd[QW] + CW'(1);
					flags_s.clip <= 1'b0;
				end else begin
					coord_s      <= NEG_MIN;
					flags_s.clip <= 1'b1;
				end
			end else if (!side_sd[QW].ovf && !quo_sd[QW][QW-1]) begin
				coord_s      <= quo_sd[QW];
				flags_s.clip <= 1'b0;
			end else begin
				coord_s      <= POS_MAX;
				flags_s.clip <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/homogeneous_point_transform_top.sv
// Top level of the homogeneous 4x4 point transform with perspective divide.
//
// One point per clock cycle is accepted while the skid register is empty, and one result
// comes out per point, in order. Each point passes the four row lanes (multiply, then sum)
// and then the coordinate lanes, whose length is set by the divider pipeline that resolves
// one quotient bit per stage over 32 stages. A skid register behind the output holds one
// more result while a result waits to be taken. Matrix coefficients are to be written through
// the register port while the block is idle; the block itself does not enforce this.
module homogeneous_point_transform_top import hpt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input point stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [3*CW-1:0]   s_tdata,  // point_x, point_y, point_z
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [3*CW-1:0]   m_tdata,  // result_x, result_y, result_z
	output logic [1:0]        m_tuser,  // w_was_zero, clipped
	// Register port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	localparam int LAT = 2 + QW + 3;
	localparam logic [CFG_DW-1:0] ONE = CFG_DW'(1) << FRAC_BITS;

	logic [CFG_DW-1:0] cfg_q [NUM_CFG];
	logic [2:0]        cfg_idx;

	logic                    en;
	logic [LAT-1:0]          vld_q;
	logic signed [SUM_W-1:0] row_sum [NUM_ROWS];
	logic [CW-1:0]           coord [3];
	coord_flags_t            cflags [3];

	logic [3*CW-1:0] out_data_q, sk_data_q;
	logic [1:0]      out_user_q, sk_user_q;
	logic            out_vld_q, sk_vld_q;
	logic [3*CW-1:0] pipe_data;
	logic [1:0]      pipe_user;
	logic            take;

	// Register file: eight 64-bit coefficient pairs, reset to the identity matrix.
	assign cfg_idx = paddr[CFG_AW-1:3];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[cfg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= ONE;
			cfg_q[1] <= '0;
			cfg_q[2] <= ONE << 32;
			cfg_q[3] <= '0;
			cfg_q[4] <= '0;
			cfg_q[5] <= ONE;
			cfg_q[6] <= '0;
			cfg_q[7] <= ONE << 32;
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[cfg_idx] <= pwdata;
		end
	end

	// The pipeline advances whenever the skid register is empty.
	assign en       = !sk_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Row lanes: x', y', z' and w in parallel.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		hpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (en),
			.x      (s_tdata[CW-1:0]),
			.y      (s_tdata[2*CW-1:CW]),
			.z      (s_tdata[3*CW-1:2*CW]),
			.coef   ({cfg_q[2*r+1], cfg_q[2*r]}),
			.sum_s2 (row_sum[r])
		);
	end

	// Coordinate lanes: divide each of the x', y' and z' row sums by w.
	for (genvar k = 0; k < 3; k++) begin : g_coord
		hpt_coord #(.FRAC_BITS(FRAC_BITS)) u_coord (
			.clk     (clk),
			.en      (en),
			.t       (row_sum[k]),
			.w       (row_sum[3]),
			.coord_s (coord[k]),
			.flags_s (cflags[k])
		);
	end

	// Merge the lanes into one result.
	assign pipe_data = {coord[2], coord[1], coord[0]};
	assign pipe_user = {cflags[0].clip | cflags[1].clip | cflags[2].clip, cflags[0].w_zero};

	// Output register with a one-entry skid behind it.
	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (sk_vld_q) begin
			if (take) begin
				sk_vld_q <= 1'b0;
			end
		end else if (vld_q[LAT-1]) begin
			if (out_vld_q && !take) begin
				sk_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_vld_q) begin
			if (take) begin
				out_data_q <= sk_data_q;
				out_user_q <= sk_user_q;
			end
		end else if (vld_q[LAT-1]) begin
			if (out_vld_q && !take) begin
				sk_data_q <= pipe_data;
				sk_user_q <= pipe_user;
			end else begin
				out_data_q <= pipe_data;
				out_user_q <= pipe_user;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// A held item in the skid register always has a result in front of it.
	assert property (@(posedge clk) disable iff (!arst_n) sk_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	// A zero w never reports clipping.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> !m_tuser[1])
		else $error("clipped set together with w_was_zero");

	// The skid register only fills while a result is stalled at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid register filled without a stalled output");

endmodule
